>>> hw/rtl/crs_pkg.sv
package crs_pkg;

    // Ring geometry.
    localparam int QUEUE_DEPTH = 128;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int IDX_W       = $clog2(QUEUE_DEPTH + 1);

    // Field widths.
    localparam int CMD_W  = 64;
    localparam int CNT_W  = 4;
    localparam int SLOT_W = 7;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [SLOT_W-1:0] slot_t;

    // Repeat count after reset.
    localparam cnt_t REPEAT_RESET = cnt_t'(3);

    // Operation codes of an input transaction.
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Write request into the retry count store.
    typedef struct packed {
        logic en;
        ptr_t idx;
        cnt_t cnt;
    } cnt_wr_t;

endpackage

>>> hw/rtl/crs_ifs.sv
// Request channel: one enqueue or service tick per transaction.
interface crs_req_if;
    logic          valid;
    logic          ready;
    logic          op;
    crs_pkg::cmd_t command;

    modport source (output valid, output op, output command, input ready);
    modport sink   (input valid, input op, input command, output ready);
endinterface

// Response channel: one result per request.
interface crs_rsp_if;
    logic           valid;
    logic           ready;
    logic           send_valid;
    crs_pkg::cmd_t  send_command;
    crs_pkg::slot_t send_slot;

    modport source (output valid, output send_valid, output send_command,
                    output send_slot, input ready);
    modport sink   (input valid, input send_valid, input send_command,
                    input send_slot, output ready);
endinterface

// Configuration write channel for the repeat count.
interface crs_cfg_if;
    logic          valid;
    logic          ready;
    crs_pkg::cnt_t repeat_count;

    modport source (output valid, output repeat_count, input ready);
    modport sink   (input valid, input repeat_count, output ready);
endinterface

>>> hw/rtl/crs_retry_store.sv
module crs_retry_store (
    input  logic             clk,
    input  logic             rst_n,
    input  crs_pkg::cnt_wr_t wr,
    input  crs_pkg::ptr_t    rd_idx,
    output crs_pkg::cnt_t    rd_cnt
);

    crs_pkg::cnt_t                       cnt_mem [crs_pkg::QUEUE_DEPTH];
    logic [crs_pkg::QUEUE_DEPTH-1:0]     vld_reg;
    crs_pkg::cnt_t                       rd_data_reg;
    logic                                rd_vld_reg;

    // Count memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            cnt_mem[wr.idx] <= wr.cnt;
        end
        rd_data_reg <= cnt_mem[rd_idx];
    end

    // Written flags make every slot read as zero straight after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.idx] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_idx];
        end
    end

    assign rd_cnt = rd_vld_reg ? rd_data_reg : '0;

endmodule

>>> hw/rtl/command_retry_scheduler_top.sv
// Enqueue: the command and its retry count are written, then the result is loaded in S_RESP.
// Service tick: the scan sequencer inspects one retry count per cycle upwards from the scan
// pointer p until a due command is found or the end of the ring is reached; the result is
// then loaded in S_RESP.
// One request at a time: a new request is taken only after the last result is loaded.
// Reset clears pointers, all retry counts (per-slot flags) and sets repeat_count to 3.
module command_retry_scheduler_top (
    input  logic      clk,
    input  logic      rst_n,
    crs_req_if.sink   req,
    crs_rsp_if.source rsp,
    crs_cfg_if.sink   cfg
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    localparam crs_pkg::idx_t DEPTH_IDX = crs_pkg::idx_t'(crs_pkg::QUEUE_DEPTH);
    localparam crs_pkg::ptr_t LAST_PTR  = crs_pkg::ptr_t'(crs_pkg::QUEUE_DEPTH - 1);

    logic [1:0]       state_reg, state_next;
    crs_pkg::ptr_t    wr_ptr_reg, wr_ptr_next;
    crs_pkg::ptr_t    scan_ptr_reg, scan_ptr_next;
    crs_pkg::idx_t    scan_idx_reg, scan_idx_next;
    crs_pkg::ptr_t    chk_idx_reg, chk_idx_next;
    logic             chk_live_reg, chk_live_next;
    logic             hit_reg, hit_next;
    crs_pkg::ptr_t    slot_reg, slot_next;
    crs_pkg::cnt_t    repeat_reg;
    logic             out_valid_reg, out_valid_next;
    logic             out_send_reg;
    crs_pkg::cmd_t    out_cmd_reg;
    crs_pkg::slot_t   out_slot_reg;
    crs_pkg::cmd_t    cmd_rd_reg;
    crs_pkg::cmd_t    cmd_mem [crs_pkg::QUEUE_DEPTH];

    logic             req_take;
    logic             cmd_we;
    logic             cmd_re;
    logic             hit;
    logic             out_load;
    crs_pkg::cnt_wr_t cnt_wr;
    crs_pkg::cnt_t    rd_cnt;
    crs_pkg::ptr_t    rd_idx;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign req_take  = req.valid && req.ready;

    // Retry count store, read at the scan index every cycle.
    assign rd_idx = scan_idx_reg[crs_pkg::PTR_W-1:0];

    crs_retry_store u_retry_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (cnt_wr),
        .rd_idx (rd_idx),
        .rd_cnt (rd_cnt)
    );

    // A slot is due when its registered count is live and nonzero.
    assign hit = (state_reg == S_SCAN) && chk_live_reg && (rd_cnt != '0);

    // Result register is free when empty or being drained this cycle.
    assign out_load = (state_reg == S_RESP) && (!out_valid_reg || rsp.ready);

    // Sequencer and pointer updates.
    always_comb
    begin
        state_next     = state_reg;
        wr_ptr_next    = wr_ptr_reg;
        scan_ptr_next  = scan_ptr_reg;
        scan_idx_next  = scan_idx_reg;
        chk_idx_next   = chk_idx_reg;
        chk_live_next  = chk_live_reg;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        cmd_we         = 1'b0;
        cmd_re         = 1'b0;
        cnt_wr.en      = 1'b0;
        cnt_wr.idx     = chk_idx_reg;
        cnt_wr.cnt     = crs_pkg::cnt_t'(rd_cnt - crs_pkg::cnt_t'(1));
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    if (req.op == crs_pkg::OP_ENQUEUE)
                    begin
                        cmd_we      = 1'b1;
                        cnt_wr.en   = 1'b1;
                        cnt_wr.idx  = wr_ptr_reg;
                        cnt_wr.cnt  = repeat_reg;
                        wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0
                                    : crs_pkg::ptr_t'(wr_ptr_reg + 1'b1);
                        hit_next    = 1'b0;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        scan_idx_next = crs_pkg::idx_t'(scan_ptr_reg);
                        chk_live_next = 1'b0;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                chk_idx_next  = crs_pkg::ptr_t'(scan_idx_reg);
                chk_live_next = (scan_idx_reg != DEPTH_IDX);
                if (scan_idx_reg != DEPTH_IDX)
                begin
                    scan_idx_next = crs_pkg::idx_t'(scan_idx_reg + 1'b1);
                end
                if (hit)
                begin
                    cnt_wr.en     = 1'b1;
                    cmd_re        = 1'b1;
                    slot_next     = chk_idx_reg;
                    hit_next      = 1'b1;
                    scan_ptr_next = (chk_idx_reg == LAST_PTR) ? '0
                                  : crs_pkg::ptr_t'(chk_idx_reg + 1'b1);
                    state_next    = S_RESP;
                end
                else if (scan_idx_reg == DEPTH_IDX)
                begin
                    hit_next      = 1'b0;
                    scan_ptr_next = '0;
                    state_next    = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wr_ptr_reg    <= '0;
            scan_ptr_reg  <= '0;
            scan_idx_reg  <= '0;
            chk_idx_reg   <= '0;
            chk_live_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            repeat_reg    <= crs_pkg::REPEAT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            scan_ptr_reg  <= scan_ptr_next;
            scan_idx_reg  <= scan_idx_next;
            chk_idx_reg   <= chk_idx_next;
            chk_live_reg  <= chk_live_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                repeat_reg <= cfg.repeat_count;
            end
        end
    end

    // Command memory and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd_we)
        begin
            cmd_mem[wr_ptr_reg] <= req.command;
        end
        if (cmd_re)
        begin
            cmd_rd_reg <= cmd_mem[chk_idx_reg];
        end
        slot_reg <= slot_next;
        if (out_load)
        begin
            out_send_reg <= hit_reg;
            out_cmd_reg  <= hit_reg ? cmd_rd_reg : '0;
            out_slot_reg <= hit_reg ? crs_pkg::slot_t'(slot_reg) : '0;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.send_valid   = out_send_reg;
    assign rsp.send_command = out_cmd_reg;
    assign rsp.send_slot    = out_slot_reg;

`ifndef NO_ASSERTIONS
    // An idle response carries an all-zero payload.
    a_idle_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.send_valid) |-> (rsp.send_command == '0 && rsp.send_slot == '0))
        else $error("idle response with nonzero payload");

    // The scan index never runs past the end of the ring.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_idx_reg <= DEPTH_IDX))
        else $error("scan index beyond ring");

    // Once a request is taken, the block is busy on the next cycle.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> !req.ready)
        else $error("request accepted while busy");

    // A hit always names a live slot with a nonzero count.
    a_hit_live: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> (chk_live_reg && chk_idx_reg <= LAST_PTR))
        else $error("hit on a slot that was not read");
`endif

endmodule

>>> dv/crs_send_checker.sv
// Watches the request, response and configuration channels of the command
// retry scheduler, predicts every response and compares it field by field.
module crs_send_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_ready,
    input  logic           req_op,
    input  crs_pkg::cmd_t  req_command,
    input  logic           rsp_valid,
    input  logic           rsp_ready,
    input  logic           rsp_send_valid,
    input  crs_pkg::cmd_t  rsp_send_command,
    input  crs_pkg::slot_t rsp_send_slot,
    input  logic           cfg_valid,
    input  logic           cfg_ready,
    input  crs_pkg::cnt_t  cfg_repeat_count,
    output int             fail_count,
    output int             outstanding,
    output int             enq_total,
    output int             sent_total,
    output int             empty_total
);
    timeunit 1ns;
    timeprecision 1ps;

    // One predicted response transaction.
    typedef struct packed {
        logic           send_valid;
        crs_pkg::cmd_t  send_command;
        crs_pkg::slot_t send_slot;
    } send_rec_t;

    // Private copy of the ring, its pointers and the repeat register.
    crs_pkg::cmd_t ring_cmd     [crs_pkg::QUEUE_DEPTH];
    crs_pkg::cnt_t ring_retries [crs_pkg::QUEUE_DEPTH];
    crs_pkg::ptr_t wr_ptr;
    crs_pkg::ptr_t scan_ptr;
    crs_pkg::cnt_t repeat_reg;
    send_rec_t     pending_sends [$];
    int            fails;
    int            n_enq;
    int            n_sent;
    int            n_empty;

    function automatic crs_pkg::ptr_t next_ptr(int p);
        return (p >= crs_pkg::QUEUE_DEPTH - 1) ? crs_pkg::ptr_t'(0)
                                               : crs_pkg::ptr_t'(p + 1);
    endfunction

    // Applies one request to the ring and returns the response it causes.
    function automatic send_rec_t schedule_step(logic op, crs_pkg::cmd_t cmd);
        send_rec_t r;
        bit        hit;
        r   = '0;
        hit = 1'b0;
        if (op == crs_pkg::OP_ENQUEUE)
        begin
            // No full check: an occupied slot is simply overwritten.
            ring_cmd[wr_ptr]     = cmd;
            ring_retries[wr_ptr] = repeat_reg;
            wr_ptr               = next_ptr(int'(wr_ptr));
        end
        else
        begin
            // Scan upwards without wrapping for the first slot still due.
            for (int i = int'(scan_ptr); i < crs_pkg::QUEUE_DEPTH && !hit; i++)
            begin
                if (ring_retries[i] != '0)
                begin
                    ring_retries[i] = ring_retries[i] - crs_pkg::cnt_t'(1);
                    r.send_valid    = 1'b1;
                    r.send_command  = ring_cmd[i];
                    r.send_slot     = crs_pkg::slot_t'(i);
                    scan_ptr        = next_ptr(i);
                    hit             = 1'b1;
                end
            end
            if (!hit)
            begin
                scan_ptr = '0;
            end
        end
        return r;
    endfunction

    // Tracks every accepted transaction on the three channels.
    always @(posedge clk or negedge rst_n)
    begin : track
        send_rec_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < crs_pkg::QUEUE_DEPTH; i++)
            begin
                ring_retries[i] = '0;
            end
            wr_ptr      = '0;
            scan_ptr    = '0;
            repeat_reg  = crs_pkg::REPEAT_RESET;
            pending_sends.delete();
            fails       = 0;
            n_enq       = 0;
            n_sent      = 0;
            n_empty     = 0;
            fail_count  <= 0;
            outstanding <= 0;
            enq_total   <= 0;
            sent_total  <= 0;
            empty_total <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                repeat_reg = cfg_repeat_count;
            end

            if (req_valid && req_ready)
            begin
                want = schedule_step(req_op, req_command);
                pending_sends.push_back(want);
                if (req_op == crs_pkg::OP_ENQUEUE)
                    n_enq++;
                else if (want.send_valid)
                    n_sent++;
                else
                    n_empty++;
            end

            if (rsp_valid && rsp_ready)
            begin
                if (pending_sends.size() == 0)
                begin
                    $display("%0t: response transaction with none expected, actual %b %h %h",
                             $time, rsp_send_valid, rsp_send_command, rsp_send_slot);
                    fails++;
                end
                else
                begin
                    want = pending_sends.pop_front();
                    if (rsp_send_valid !== want.send_valid)
                    begin
                        $display("%0t: send_valid mismatch, expected %b, actual %b",
                                 $time, want.send_valid, rsp_send_valid);
                        fails++;
                    end
                    if (rsp_send_command !== want.send_command)
                    begin
                        $display("%0t: send_command mismatch, expected %h, actual %h",
                                 $time, want.send_command, rsp_send_command);
                        fails++;
                    end
                    if (rsp_send_slot !== want.send_slot)
                    begin
                        $display("%0t: send_slot mismatch, expected %0d, actual %0d",
                                 $time, want.send_slot, rsp_send_slot);
                        fails++;
                    end
                end
            end

            fail_count  <= fails;
            outstanding <= pending_sends.size();
            enq_total   <= n_enq;
            sent_total  <= n_sent;
            empty_total <= n_empty;
        end
    end

endmodule

>>> dv/command_retry_scheduler_top_tb.sv
// Stimulus and verdict for the command retry scheduler.
module command_retry_scheduler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 9;
    localparam int PHASE_ITEMS    = 150;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    crs_req_if req_ch ();
    crs_rsp_if rsp_ch ();
    crs_cfg_if cfg_ch ();

    int fail_count;
    int outstanding;
    int enq_total;
    int sent_total;
    int empty_total;
    int config_writes = 0;
    int idle_cycles   = 0;
    bit idle_on       = 1'b1;
    bit quiet_tail    = 1'b0;

    command_retry_scheduler_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    crs_send_checker send_monitor (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_ch.valid),
        .req_ready        (req_ch.ready),
        .req_op           (req_ch.op),
        .req_command      (req_ch.command),
        .rsp_valid        (rsp_ch.valid),
        .rsp_ready        (rsp_ch.ready),
        .rsp_send_valid   (rsp_ch.send_valid),
        .rsp_send_command (rsp_ch.send_command),
        .rsp_send_slot    (rsp_ch.send_slot),
        .cfg_valid        (cfg_ch.valid),
        .cfg_ready        (cfg_ch.ready),
        .cfg_repeat_count (cfg_ch.repeat_count),
        .fail_count       (fail_count),
        .outstanding      (outstanding),
        .enq_total        (enq_total),
        .sent_total       (sent_total),
        .empty_total      (empty_total)
    );

    always #1 clk = ~clk;

    // Response back-pressure in random bursts; none when idle_on is clear or in the tail of the run.
    initial
    begin : rsp_stall
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!idle_on || quiet_tail)
            begin
                stall_left = 0;
                rsp_ch.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Ends the run when no transaction has moved for too long.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic crs_pkg::cmd_t rand_command();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Offers one request transaction and returns at the edge that accepts it.
    task automatic send_item(logic op, crs_pkg::cmd_t cmd);
        if (idle_on && !quiet_tail && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.op      <= op;
        req_ch.command <= cmd;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    // Stops offering requests until every predicted response has been taken.
    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // Writes the repeat count while the block is idle.
    task automatic write_repeat(crs_pkg::cnt_t value);
        hold_until_drained();
        cfg_ch.valid        <= 1'b1;
        cfg_ch.repeat_count <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        config_writes++;
    endtask

    initial
    begin : stimulus
        logic          op;
        int            enq_pct;
        crs_pkg::cnt_t rep;

        req_ch.valid        = 1'b0;
        req_ch.op           = crs_pkg::OP_ENQUEUE;
        req_ch.command      = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.repeat_count = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: a tick on the empty ring, then commands at the field extremes.
        send_item(crs_pkg::OP_TICK, '0);
        send_item(crs_pkg::OP_ENQUEUE, '0);
        send_item(crs_pkg::OP_ENQUEUE, '1);
        send_item(crs_pkg::OP_ENQUEUE, 64'h5555_5555_5555_5555);
        send_item(crs_pkg::OP_ENQUEUE, 64'hAAAA_AAAA_AAAA_AAAA);
        // Four sends, then a scan off the top of the ring, then back to slot 0.
        repeat (6) send_item(crs_pkg::OP_TICK, '1);

        // A zero repeat count stores a command that is never sent.
        write_repeat(crs_pkg::cnt_t'(0));
        send_item(crs_pkg::OP_ENQUEUE, 64'h8000_0000_0000_0001);
        send_item(crs_pkg::OP_TICK, '0);
        send_item(crs_pkg::OP_TICK, '0);

        // Largest and smallest nonzero repeat counts.
        write_repeat(crs_pkg::cnt_t'(15));
        send_item(crs_pkg::OP_ENQUEUE, '1);
        send_item(crs_pkg::OP_TICK, '0);
        write_repeat(crs_pkg::cnt_t'(1));
        send_item(crs_pkg::OP_ENQUEUE, '0);
        send_item(crs_pkg::OP_TICK, '0);
        send_item(crs_pkg::OP_TICK, '0);
        send_item(crs_pkg::OP_TICK, '0);

        // Random phases, each with its own repeat count and request mix.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       rep = crs_pkg::cnt_t'(15);
                1:       rep = crs_pkg::cnt_t'(1);
                2:       rep = crs_pkg::cnt_t'(0);
                3:       rep = crs_pkg::cnt_t'(15);
                4:       rep = crs_pkg::cnt_t'(2);
                5:       rep = crs_pkg::cnt_t'($urandom_range(1, 15));
                6:       rep = crs_pkg::cnt_t'(4);
                7:       rep = crs_pkg::cnt_t'($urandom_range(0, 15));
                default: rep = crs_pkg::REPEAT_RESET;
            endcase
            write_repeat(rep);
            idle_on    = (p == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
            quiet_tail = (p == PHASES - 1);
            enq_pct    = $urandom_range(15, 70);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k == PHASE_ITEMS / 2)
                    hold_until_drained();
                // Phase four fills past the ring size so that live slots are overwritten.
                if (p == 4 && k < 140)
                    op = crs_pkg::OP_ENQUEUE;
                else
                    op = ($urandom_range(0, 99) < enq_pct) ? crs_pkg::OP_ENQUEUE
                                                            : crs_pkg::OP_TICK;
                send_item(op, rand_command());
            end
        end

        // Let the last responses arrive and give the block time to misbehave.
        hold_until_drained();
        repeat (crs_pkg::QUEUE_DEPTH + 8) @(posedge clk);

        $display("Covered %0d enqueues and %0d service ticks over %0d repeat count writes.",
                 enq_total, sent_total + empty_total, config_writes);
        $display("Ticks that issued a command: %0d; ticks that found nothing due: %0d.",
                 sent_total, empty_total);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
